@@ sv/ptsamp_pkg.sv @@
// Shared types, constants and helpers for the polynomial trajectory sampler.
// No dependencies; used by ptsamp_curv and polynomial_trajectory_sampler_core.
package ptsamp_pkg;

   localparam int NUM_AXES  = 3;
   localparam int NUM_DERIV = 3;
   localparam int NUM_RES   = NUM_AXES * NUM_DERIV;
   localparam int RES_IDX_W = 4;
   localparam int FRAC_BITS = 16;
   localparam int FACT_W    = 8;
   localparam int SUM_W     = 68;
   localparam int CSR_IDX_W = 2;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER  = 2'd2;

   typedef logic [NUM_AXES-1:0][31:0] vec3_type;

   typedef struct packed {
      logic        done;
      logic [31:0] kappa;
   } curv_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] hi_lim;
      logic signed [SUM_W-1:0] lo_lim;
      hi_lim = SUM_W'(32'sh7FFF_FFFF);
      lo_lim = SUM_W'(32'sh8000_0000);
      if (x > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo_lim) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

@@ sv/ptsamp_curv.sv @@
// Curvature unit: |v x a| / |v|^3 with a shared 33x33 multiplier,
// a digit-by-digit square root and a restoring divider. Depends on ptsamp_pkg.
module ptsamp_curv
   import ptsamp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  vec3_type        vel,
   input  vec3_type        acl,
   output curv_status_type status
);

   typedef enum logic [2:0] {
      CV_IDLE, CV_VV, CV_SQ_SPD, CV_CROSS, CV_SQ_MAG, CV_CUBE, CV_DIV
   } cv_state_type;

   cv_state_type          state_ff;
   logic [1:0]            k_ff;
   logic [2:0]            stp_ff;
   logic [6:0]            cnt_ff;
   logic signed [65:0]    prod_ff;
   logic [127:0]          acc_ff;
   logic [63:0]           hold_ff;
   logic [63:0]           mag_ff;
   logic [31:0]           spd_ff;
   logic [66:0]           sq_rem_ff;
   logic [63:0]           root_ff;
   logic [95:0]           dvs_ff;
   logic [95:0]           num_ff;
   logic [96:0]           dv_rem_ff;
   logic [95:0]           quo_ff;
   logic                  done_ff;
   logic [31:0]           kappa_ff;

   logic signed [32:0]    mul_a;
   logic signed [32:0]    mul_b;
   logic [1:0]            k1;
   logic [1:0]            k2;
   logic [66:0]           sq_rem_n;
   logic [66:0]           sq_trial;
   logic                  sq_ge;
   logic [63:0]           root_n;
   logic [96:0]           dv_rem_n;
   logic                  dv_ge;
   logic [95:0]           quo_n;
   logic signed [64:0]    cross_diff;

   assign k1 = (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
   assign k2 = (k_ff == 2'd0) ? 2'd2 : k_ff - 2'd1;

   assign sq_rem_n = {sq_rem_ff[64:0], acc_ff[127:126]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = (sq_rem_n >= sq_trial);
   assign root_n   = {root_ff[62:0], sq_ge};

   assign dv_rem_n = {dv_rem_ff[95:0], num_ff[95]};
   assign dv_ge    = (dv_rem_n >= {1'b0, dvs_ff});
   assign quo_n    = {quo_ff[94:0], dv_ge};

   assign cross_diff = $signed({hold_ff[63], hold_ff}) - $signed({prod_ff[63], prod_ff[63:0]});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         CV_VV: begin
            mul_a = $signed({vel[k_ff][31], vel[k_ff]});
            mul_b = $signed({vel[k_ff][31], vel[k_ff]});
         end
         CV_CROSS: begin
            unique case (stp_ff)
               3'd0: begin
                  mul_a = $signed({vel[k1][31], vel[k1]});
                  mul_b = $signed({acl[k2][31], acl[k2]});
               end
               3'd1: begin
                  mul_a = $signed({vel[k2][31], vel[k2]});
                  mul_b = $signed({acl[k1][31], acl[k1]});
               end
               3'd3: begin
                  mul_a = $signed({1'b0, mag_ff[31:0]});
                  mul_b = $signed({1'b0, mag_ff[31:0]});
               end
               3'd4: begin
                  mul_a = $signed({1'b0, mag_ff[31:0]});
                  mul_b = $signed({1'b0, mag_ff[63:32]});
               end
               3'd5: begin
                  mul_a = $signed({1'b0, mag_ff[63:32]});
                  mul_b = $signed({1'b0, mag_ff[63:32]});
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         CV_CUBE: begin
            unique case (stp_ff)
               3'd0: begin
                  mul_a = $signed({1'b0, spd_ff});
                  mul_b = $signed({1'b0, spd_ff});
               end
               3'd2: begin
                  mul_a = $signed({1'b0, hold_ff[31:0]});
                  mul_b = $signed({1'b0, spd_ff});
               end
               3'd3: begin
                  mul_a = $signed({1'b0, hold_ff[63:32]});
                  mul_b = $signed({1'b0, spd_ff});
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         done_ff  <= 1'b0;
         k_ff     <= '0;
         stp_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            CV_IDLE: begin
               done_ff <= 1'b0;
               if (go) begin
                  acc_ff   <= '0;
                  k_ff     <= '0;
                  stp_ff   <= '0;
                  state_ff <= CV_VV;
               end
            end
            CV_VV: begin
               if (stp_ff == 3'd0) begin
                  stp_ff <= 3'd1;
               end else begin
                  acc_ff <= acc_ff + 128'(prod_ff[63:0]);
                  stp_ff <= 3'd0;
                  if (k_ff == 2'd2) begin
                     sq_rem_ff <= '0;
                     root_ff   <= '0;
                     cnt_ff    <= '0;
                     state_ff  <= CV_SQ_SPD;
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end
            end
            CV_SQ_SPD, CV_SQ_MAG: begin
               acc_ff    <= ((cnt_ff == 7'd63) && (state_ff == CV_SQ_SPD)) ? '0
                                                                            : acc_ff << 2;
               sq_rem_ff <= sq_ge ? (sq_rem_n - sq_trial) : sq_rem_n;
               root_ff   <= root_n;
               cnt_ff    <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) begin
                  k_ff   <= '0;
                  stp_ff <= '0;
                  if (state_ff == CV_SQ_SPD) begin
                     spd_ff <= root_n[31:0];
                     if (root_n == 64'd0) begin
                        kappa_ff <= 32'hFFFF_FFFF;
                        done_ff  <= 1'b1;
                        state_ff <= CV_IDLE;
                     end else begin
                        state_ff <= CV_CROSS;
                     end
                  end else begin
                     num_ff   <= {root_n, 32'd0};
                     state_ff <= CV_CUBE;
                  end
               end
            end
            CV_CROSS: begin
               stp_ff <= (stp_ff == 3'd6) ? 3'd0 : stp_ff + 3'd1;
               unique case (stp_ff)
                  3'd1: hold_ff <= prod_ff[63:0];
                  3'd2: mag_ff  <= cross_diff[64] ? 64'(-cross_diff) : cross_diff[63:0];
                  3'd4: acc_ff  <= acc_ff + 128'(prod_ff[63:0]);
                  3'd5: acc_ff  <= acc_ff + (128'(prod_ff[63:0]) << 33);
                  3'd6: begin
                     acc_ff <= acc_ff + (128'(prod_ff[63:0]) << 64);
                     if (k_ff == 2'd2) begin
                        sq_rem_ff <= '0;
                        root_ff   <= '0;
                        cnt_ff    <= '0;
                        state_ff  <= CV_SQ_MAG;
                     end else begin
                        k_ff <= k_ff + 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CV_CUBE: begin
               stp_ff <= (stp_ff == 3'd4) ? 3'd0 : stp_ff + 3'd1;
               unique case (stp_ff)
                  3'd1: hold_ff <= prod_ff[63:0];
                  3'd3: dvs_ff  <= 96'(prod_ff[63:0]);
                  3'd4: begin
                     dvs_ff    <= dvs_ff + {prod_ff[63:0], 32'd0};
                     dv_rem_ff <= '0;
                     quo_ff    <= '0;
                     cnt_ff    <= '0;
                     state_ff  <= CV_DIV;
                  end
                  default: begin
                  end
               endcase
            end
            CV_DIV: begin
               num_ff    <= num_ff << 1;
               dv_rem_ff <= dv_ge ? (dv_rem_n - {1'b0, dvs_ff}) : dv_rem_n;
               quo_ff    <= quo_n;
               cnt_ff    <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd95) begin
                  kappa_ff <= (|quo_n[95:32]) ? 32'hFFFF_FFFF : quo_n[31:0];
                  done_ff  <= 1'b1;
                  state_ff <= CV_IDLE;
               end
            end
            default: state_ff <= CV_IDLE;
         endcase
      end
   end

   assign status.done  = done_ff;
   assign status.kappa = kappa_ff;

endmodule

@@ sv/polynomial_trajectory_sampler_core.sv @@
// Top level of the polynomial trajectory sampler: coefficient memory, Horner sequencer
// and result register. Depends on ptsamp_pkg and ptsamp_curv.
//
//   channel | direction | handshake            | carries
//   req_    | in        | req_valid/req_ready  | load or sample transaction
//   rsp_    | out       | rsp_valid/rsp_ready  | position, velocity, accel, curvature
//   csr_    | in        | csr_we               | start, length, order registers
//
// A load transaction writes the coefficient memory and leaves the block ready for the next
// request. A sample transaction runs nine Horner evaluations, each term read through the single
// coefficient memory read port, then multiplied and added, and then the curvature unit's square roots and divider.
// Reset is synchronous; the coefficient memory reads as zero until an entry is written.
// A finished result waits in the output register while the next transaction is taken.
module polynomial_trajectory_sampler_core
   import ptsamp_pkg::*;
#(
   parameter int MAX_ORDER = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [1:0]           req_axis,
   input  logic [2:0]           req_power,
   input  logic signed [31:0]   req_coef_value,
   input  logic [31:0]          req_sample_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_position_x,
   output logic signed [31:0]   rsp_position_y,
   output logic signed [31:0]   rsp_position_z,
   output logic signed [31:0]   rsp_velocity_x,
   output logic signed [31:0]   rsp_velocity_y,
   output logic signed [31:0]   rsp_velocity_z,
   output logic signed [31:0]   rsp_accel_x,
   output logic signed [31:0]   rsp_accel_y,
   output logic signed [31:0]   rsp_accel_z,
   output logic [31:0]          rsp_path_curvature,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int ROWS   = MAX_ORDER + 1;
   localparam int DEPTH  = NUM_AXES * ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TERM_W = $clog2(ROWS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVAL, ST_RD, ST_MUL, ST_ADD, ST_STORE, ST_CURV, ST_WAIT_CURV, ST_OUT
   } state_type;

   logic [31:0]          start_ff;
   logic [31:0]          length_ff;
   logic [2:0]           order_csr_ff;

   logic [31:0]          mem [DEPTH];
   logic                 vld_ff [DEPTH];
   logic [31:0]          rd_data_ff;
   logic                 rd_vld_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [ADDR_W-1:0]    mem_raddr;

   state_type            state_ff;
   logic [31:0]          t_ff;
   logic [TERM_W-1:0]    order_ff;
   logic [1:0]           j_ff;
   logic [1:0]           ax_ff;
   logic [TERM_W-1:0]    i_ff;
   logic signed [31:0]   acc_ff;
   logic signed [64:0]   prod_ff;
   logic signed [40:0]   cf_ff;
   logic signed [31:0]   res_ff [NUM_RES];
   logic signed [31:0]   rsp_ff [NUM_RES];
   logic [31:0]          kappa_ff;
   logic                 rsp_valid_ff;
   logic                 curv_go_ff;
   logic [31:0]          kappa_in;

   logic                 req_fire;
   logic [32:0]          win_end_full;
   logic [31:0]          win_end;
   logic [31:0]          t_in;
   logic [TERM_W-1:0]    order_in;
   logic [FACT_W-1:0]    i_wide;
   logic [FACT_W-1:0]    fact;
   logic signed [31:0]   coef;
   logic signed [SUM_W-1:0] step_sum;
   vec3_type             curv_vel;
   vec3_type             curv_acl;
   curv_status_type      curv_st;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         length_ff    <= '0;
         order_csr_ff <= '0;
      end else if (csr_we) begin
         priority case (csr_index)
            CSR_START:  start_ff     <= csr_wdata;
            CSR_LENGTH: length_ff    <= csr_wdata;
            CSR_ORDER:  order_csr_ff <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   assign mem_we = req_fire && (req_func == FUNC_LOAD) && (req_axis < 2'(NUM_AXES))
                   && (32'(req_power) <= 32'(MAX_ORDER));
   assign mem_waddr = ADDR_W'(32'(req_axis) * ROWS + 32'(req_power));
   assign mem_raddr = ADDR_W'(32'(ax_ff) * ROWS + 32'(i_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_coef_value;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < DEPTH; n++) begin
            vld_ff[n] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[mem_raddr];
      end
   end

   assign coef = rd_vld_ff ? $signed(rd_data_ff) : 32'sd0;

   assign win_end_full = {1'b0, start_ff} + {1'b0, length_ff};
   assign win_end      = win_end_full[32] ? 32'hFFFF_FFFF : win_end_full[31:0];
   assign t_in = (req_sample_time < start_ff) ? start_ff :
                 (req_sample_time > win_end) ? win_end : req_sample_time;
   assign order_in = (32'(order_csr_ff) > 32'(MAX_ORDER)) ? TERM_W'(MAX_ORDER)
                                                          : TERM_W'(order_csr_ff);

   assign i_wide = FACT_W'(i_ff);
   always_comb begin
      priority if (j_ff == 2'd0) begin
         fact = FACT_W'(1);
      end else if (j_ff == 2'd1) begin
         fact = i_wide;
      end else begin
         fact = FACT_W'(i_wide * (i_wide - FACT_W'(1)));
      end
   end

   assign step_sum = (SUM_W'(prod_ff) >>> FRAC_BITS) + SUM_W'(cf_ff);

   assign curv_vel = {res_ff[5], res_ff[4], res_ff[3]};
   assign curv_acl = {res_ff[8], res_ff[7], res_ff[6]};
   assign kappa_in = curv_st.kappa;

   ptsamp_curv u_curv (
      .clock  (clock),
      .reset  (reset),
      .go     (curv_go_ff),
      .vel    (curv_vel),
      .acl    (curv_acl),
      .status (curv_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         curv_go_ff   <= 1'b0;
         j_ff         <= '0;
         ax_ff        <= '0;
         i_ff         <= '0;
      end else begin
         curv_go_ff <= (state_ff == ST_CURV);
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_func == FUNC_SAMPLE)) begin
                  t_ff     <= t_in;
                  order_ff <= order_in;
                  j_ff     <= '0;
                  ax_ff    <= '0;
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               acc_ff <= '0;
               i_ff   <= order_ff;
               state_ff <= (32'(order_ff) < 32'(j_ff)) ? ST_STORE : ST_RD;
            end
            ST_RD: state_ff <= ST_MUL;
            ST_MUL: begin
               prod_ff  <= acc_ff * $signed({1'b0, t_ff});
               cf_ff    <= coef * $signed({1'b0, fact});
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               acc_ff <= sat32(step_sum);
               if (32'(i_ff) == 32'(j_ff)) begin
                  state_ff <= ST_STORE;
               end else begin
                  i_ff     <= i_ff - TERM_W'(1);
                  state_ff <= ST_RD;
               end
            end
            ST_STORE: begin
               res_ff[RES_IDX_W'(32'(j_ff) * NUM_AXES + 32'(ax_ff))] <= acc_ff;
               state_ff <= ST_EVAL;
               if (ax_ff == 2'(NUM_AXES - 1)) begin
                  ax_ff <= '0;
                  if (j_ff == 2'(NUM_DERIV - 1)) begin
                     state_ff <= ST_CURV;
                  end else begin
                     j_ff <= j_ff + 2'd1;
                  end
               end else begin
                  ax_ff <= ax_ff + 2'd1;
               end
            end
            ST_CURV: begin
               state_ff <= ST_WAIT_CURV;
            end
            ST_WAIT_CURV: begin
               if (curv_st.done) begin
                  kappa_ff <= kappa_in;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  for (int n = 0; n < NUM_RES; n++) begin
                     rsp_ff[n] <= res_ff[n];
                  end
                  rsp_path_curvature <= kappa_ff;
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position_x = rsp_ff[0];
   assign rsp_position_y = rsp_ff[1];
   assign rsp_position_z = rsp_ff[2];
   assign rsp_velocity_x = rsp_ff[3];
   assign rsp_velocity_y = rsp_ff[4];
   assign rsp_velocity_z = rsp_ff[5];
   assign rsp_accel_x    = rsp_ff[6];
   assign rsp_accel_y    = rsp_ff[7];
   assign rsp_accel_z    = rsp_ff[8];

   a_sample_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_func == FUNC_SAMPLE)) |=> (state_ff != ST_IDLE))
      else $error("sample transaction did not start an evaluation");

   a_load_no_response: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_func == FUNC_LOAD) && !rsp_valid) |=> !rsp_valid)
      else $error("load transaction produced a response");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (32'(i_ff) >= 32'(j_ff)))
      else $error("Horner term index fell below derivative order");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for polynomial_trajectory_sampler_core: drives load and sample
// transactions, predicts each result in a behavioral model, and checks the results.
// Depends on ptsamp_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench
   import ptsamp_pkg::*;
();

   localparam int  MAX_POWER   = 7;
   localparam int  SETTLE      = 600;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam logic [31:0] KAPPA_MAX = 32'hFFFF_FFFF;

   typedef struct {
      logic [31:0] field [10];
   } traj_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = FUNC_LOAD;
   logic [1:0] req_axis = '0;
   logic [2:0] req_power = '0;
   logic signed [31:0] req_coef_value = '0;
   logic [31:0] req_sample_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_position_x, rsp_position_y, rsp_position_z;
   logic signed [31:0] rsp_velocity_x, rsp_velocity_y, rsp_velocity_z;
   logic signed [31:0] rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic [31:0] rsp_path_curvature;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_START;
   logic [31:0] csr_wdata = '0;

   logic [31:0] win_start, win_len;
   logic [2:0]  order_sel;
   logic signed [31:0] coef_mem [NUM_AXES][MAX_POWER+1];
   traj_sample_type pending_samples [$];

   int cycle_count = 0;
   int mismatches = 0;
   int samples_checked = 0;
   int loads_sent = 0;
   int burst_left = 0;
   bit bursty = 1'b1;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_len = 0;
   int hold_left = 0;
   bit rx_fast = 1'b0;
   int rx_phase = 0;

   polynomial_trajectory_sampler_core u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic logic signed [31:0] horner_eval(int ax, int j, logic [31:0] t, int ord);
      longint acc;
      longint tt;
      longint f;
      longint prod;
      acc = 0;
      tt = longint'({32'b0, t});
      for (int i = ord; i >= j; i--) begin
         f = 1;
         for (int k = 0; k < j; k++) f = f * (i - k);
         prod = acc * tt;
         acc = (prod >>> 16) + longint'(coef_mem[ax][i]) * f;
         if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
         else if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
      end
      return acc[31:0];
   endfunction

   function automatic logic [63:0] isqrt_wide(logic [127:0] s);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'b0, cand} * {64'b0, cand} <= s) res = cand;
      end
      return res;
   endfunction

   function automatic logic [31:0] curvature_of(logic signed [31:0] v [3],
                                                logic signed [31:0] a [3]);
      logic signed [65:0] c [3];
      logic signed [65:0] vs [3];
      logic signed [65:0] as [3];
      logic [127:0] acc_sq, speed_sq, mg, num, den, quo;
      logic [63:0] speed, mag;
      for (int k = 0; k < 3; k++) begin
         vs[k] = v[k];
         as[k] = a[k];
      end
      c[0] = vs[1] * as[2] - vs[2] * as[1];
      c[1] = vs[2] * as[0] - vs[0] * as[2];
      c[2] = vs[0] * as[1] - vs[1] * as[0];
      speed_sq = '0;
      acc_sq = '0;
      for (int k = 0; k < 3; k++) begin
         speed_sq = speed_sq + 128'(vs[k] * vs[k]);
         mg = c[k] < 0 ? 128'(-c[k]) : 128'(c[k]);
         acc_sq = acc_sq + mg * mg;
      end
      speed = isqrt_wide(speed_sq);
      if (speed == 0) return KAPPA_MAX;
      mag = isqrt_wide(acc_sq);
      den = {64'b0, speed} * {64'b0, speed} * {64'b0, speed};
      num = {32'b0, mag, 32'b0};
      quo = num / den;
      if (quo > 128'(KAPPA_MAX)) return KAPPA_MAX;
      return quo[31:0];
   endfunction

   function automatic traj_sample_type predict_sample(logic [31:0] t_in);
      traj_sample_type r;
      logic [32:0] win_end;
      logic [31:0] t, stop;
      logic signed [31:0] vel [3];
      logic signed [31:0] acl [3];
      win_end = {1'b0, win_start} + {1'b0, win_len};
      stop = win_end[32] ? 32'hFFFF_FFFF : win_end[31:0];
      t = t_in;
      if (t < win_start) t = win_start;
      if (t > stop) t = stop;
      for (int j = 0; j < NUM_DERIV; j++)
         for (int ax = 0; ax < NUM_AXES; ax++)
            r.field[j*NUM_AXES + ax] = horner_eval(ax, j, t, order_sel);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         vel[ax] = r.field[NUM_AXES + ax];
         acl[ax] = r.field[2*NUM_AXES + ax];
      end
      r.field[9] = curvature_of(vel, acl);
      return r;
   endfunction

   task automatic send_item(logic func, logic [1:0] axis, logic [2:0] power,
                            logic [31:0] coef, logic [31:0] t);
      if (bursty && burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left = burst_left > 0 ? burst_left - 1 : 0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_axis <= axis;
      req_power <= power;
      req_coef_value <= coef;
      req_sample_time <= t;
      do @(posedge clock); while (!req_ready);
      if (func == FUNC_LOAD) begin
         loads_sent++;
         if (axis < NUM_AXES) coef_mem[axis][power] = coef;
      end else begin
         pending_samples.insert(pending_samples.size(), predict_sample(t));
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START:  win_start = value;
         CSR_LENGTH: win_len = value;
         CSR_ORDER:  order_sel = value[2:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
         default: return 32'($urandom_range(0, 32'h0000_0800)) - 32'h0000_0400;
      endcase
   endfunction

   function automatic logic [31:0] rand_time();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return win_start - 32'($urandom_range(0, 4096));
         2: return win_start + win_len + 32'($urandom_range(0, 4096));
         default: return win_start + 32'($urandom_range(0, 32'h0003_0000));
      endcase
   endfunction

   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rx_phase <= rx_phase + 1;
         if (rx_phase % 97 == 0) rx_fast <= ~rx_fast;
         rsp_ready <= rx_fast ? 1'b1 : ((rx_phase % 7) < 4);
      end
   end

   always @(posedge clock) begin
      traj_sample_type want;
      logic [31:0] got [10];
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_position_x, rsp_position_y, rsp_position_z,
                 rsp_velocity_x, rsp_velocity_y, rsp_velocity_z,
                 rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_path_curvature};
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
         end else begin
            want = pending_samples.pop_front();
            samples_checked++;
            for (int k = 0; k < 10; k++)
               if (got[k] !== want.field[k]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d field %0d: expected %h actual %h",
                              samples_checked, k, want.field[k], got[k]);
               end
         end
      end
   end

   task automatic test_reset_state();
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'd0);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_directed();
      write_csr(CSR_ORDER, 3'd7);
      write_csr(CSR_START, 32'hFFFF_0000);
      write_csr(CSR_LENGTH, 32'hFFFF_FFFF);
      for (int p = 0; p <= MAX_POWER; p++)
         send_item(FUNC_LOAD, 2'(p % 3), 3'(p), p[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 0);
      send_item(FUNC_LOAD, 2'd3, 3'd1, 32'h1234_5678, 0);
      send_item(FUNC_SAMPLE, 2'd3, 3'd7, 32'hFFFF_FFFF, 32'd0);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'hFFFF_FFFF);
      write_csr(CSR_START, 32'h0001_0000);
      write_csr(CSR_LENGTH, 32'h0002_0000);
      send_item(FUNC_LOAD, 2'd0, 3'd1, 32'h0001_0000, 0);
      send_item(FUNC_LOAD, 2'd1, 3'd2, 32'h0000_8000, 0);
      send_item(FUNC_LOAD, 2'd2, 3'd3, 32'hFFFF_0000, 0);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'h0000_0100);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'h0001_8000);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'h7FFF_FFFF);
      write_csr(CSR_ORDER, 3'd1);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'h0001_4000);
      write_csr(CSR_ORDER, 3'd0);
      send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, 32'h0001_4000);
   endtask

   task automatic test_random_phases(int phases, int per_phase);
      logic [31:0] s, l;
      for (int ph = 0; ph < phases; ph++) begin
         case (ph % 4)
            0: begin s = 32'd0; l = $urandom_range(0, 32'h0004_0000); end
            1: begin s = $urandom; l = $urandom; end
            2: begin s = 32'hFFFF_FFFF; l = 32'hFFFF_FFFF; end
            default: begin s = $urandom_range(0, 32'h0008_0000); l = 32'd0; end
         endcase
         write_csr(CSR_START, s);
         write_csr(CSR_LENGTH, l);
         write_csr(CSR_ORDER, ph == 0 ? 3'd0 : (ph == 1 ? 3'd7 : 3'($urandom_range(0, 7))));
         bursty = (ph % 3 != 2);
         for (int n = 0; n < per_phase; n++) begin
            if ($urandom_range(0, 9) < 4)
               send_item(FUNC_LOAD, $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                         3'($urandom_range(0, 7)), rand_coef(), $urandom);
            else
               send_item(FUNC_SAMPLE, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         $urandom, rand_time());
         end
      end
      bursty = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_len = 4000;
      @(negedge clock);
      req_valid <= 1'b0;
      hold_request = hold_request + 1;
      for (int n = 0; n < 12; n++)
         send_item(FUNC_SAMPLE, 2'd0, 3'd0, 32'd0, rand_time());
   endtask

   task automatic test_drained_pause();
      drain_results();
      for (int n = 0; n < 6; n++)
         send_item(FUNC_SAMPLE, 2'd1, 3'd2, 32'd0, rand_time());
   endtask

   initial begin
      for (int ax = 0; ax < NUM_AXES; ax++)
         for (int p = 0; p <= MAX_POWER; p++) coef_mem[ax][p] = '0;
      win_start = '0;
      win_len = '0;
      order_sel = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed();
      test_random_phases(6, 240);
      test_backpressure();
      test_drained_pause();
      drain_results();
      $display("covered %0d checked samples and %0d loads over several window and order settings",
               samples_checked, loads_sent);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/ptsamp_pkg.sv
sv/ptsamp_curv.sv
sv/polynomial_trajectory_sampler_core.sv
dv/testbench.sv
